// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_AT(label, clk, rst_n, !(cond))

`endif

// ===== rtl/bsas_pkg.sv =====
package bsas_pkg;

    // Default pattern store depth
    localparam int MAX_PATTERN_DEF = 63;
    // Beats held between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 6;
    // Length after widening, holds MAX_PATTERN up to 255
    localparam int LEN_EXT_W = 8;
    localparam int OFFSET_W  = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;

    // Classified operation carried from front to back
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_TEXT  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] pattern_index;
    } q_entry_t;

endpackage

// ===== rtl/bsas_front.sv =====
module bsas_front #(
    parameter int MAX_PATTERN = bsas_pkg::MAX_PATTERN_DEF
) (
    input  logic [bsas_pkg::CMD_W-1:0]   command,
    input  logic [bsas_pkg::BYTE_W-1:0]  data_byte,
    input  logic [bsas_pkg::INDEX_W-1:0] pattern_index,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         q_full,
    output logic                         q_push,
    output bsas_pkg::q_entry_t           q_entry
);

    bsas_pkg::op_t op;

    always_comb
    begin
        case (command)
            bsas_pkg::CMD_LOAD:
            begin
                // loads past the store are dropped but still answered
                op = (32'(pattern_index) < MAX_PATTERN) ? bsas_pkg::OP_LOAD
                                                        : bsas_pkg::OP_NONE;
            end
            bsas_pkg::CMD_START: op = bsas_pkg::OP_START;
            bsas_pkg::CMD_TEXT:  op = bsas_pkg::OP_TEXT;
            default:             op = bsas_pkg::OP_NONE;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign q_entry.op            = op;
    assign q_entry.data_byte     = data_byte;
    assign q_entry.pattern_index = pattern_index;

endmodule

// ===== rtl/bsas_queue.sv =====
`include "assert_macros.svh"

module bsas_queue #(
    parameter int DEPTH = bsas_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bsas_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output bsas_pkg::q_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsas_pkg::q_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && (count_reg == '0))
    `ASSERT_AT(a_q_count, clk, rst_n, rst_n |=> count_reg == $past(count_next))
    `ASSERT_NEVER(a_q_overflow, clk, rst_n, count_reg > CNT_W'(DEPTH))

endmodule

// ===== rtl/bsas_back.sv =====
`include "assert_macros.svh"

module bsas_back #(
    parameter int MAX_PATTERN = bsas_pkg::MAX_PATTERN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bsas_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          q_valid,
    input  bsas_pkg::q_entry_t            q_entry,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_match,
    output logic [bsas_pkg::OFFSET_W-1:0] out_match_start,
    output logic                          out_first
);

    localparam int LW = bsas_pkg::LEN_EXT_W;
    localparam int OW = bsas_pkg::OFFSET_W;

    logic [bsas_pkg::BYTE_W-1:0] pat_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      vec_reg, vec_next;
    logic [OW-1:0]               offset_reg, offset_next;
    logic                        found_reg, found_next;
    logic [bsas_pkg::LEN_W-1:0]  len_reg;
    logic                        out_valid_reg;
    logic                        out_match_reg, out_match_next;
    logic [OW-1:0]               out_start_reg, out_start_next;
    logic                        out_first_reg, out_first_next;

    logic [MAX_PATTERN-1:0] mask;
    logic [MAX_PATTERN-1:0] sel;
    logic [MAX_PATTERN:0]   shifted;
    logic [MAX_PATTERN-1:0] vec_text;
    logic [LW-1:0]          len_wide, len_eff, bit_pos;
    logic                   hit;
    logic                   is_text, is_start, is_load;

    assign q_pop    = q_valid && (!out_valid_reg || out_ready);
    assign is_text  = q_pop && (q_entry.op == bsas_pkg::OP_TEXT);
    assign is_start = q_pop && (q_entry.op == bsas_pkg::OP_START);
    assign is_load  = q_pop && (q_entry.op == bsas_pkg::OP_LOAD);

    // length clamped to the store depth
    assign len_wide = LW'(len_reg);
    assign len_eff  = (len_wide > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : len_wide;
    assign bit_pos  = len_eff - LW'(1);

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            mask[i] = (pat_reg[i] == q_entry.data_byte);
            sel[i]  = (len_eff == LW'(i + 1));
        end
    end

    assign shifted  = {vec_reg, 1'b1};
    assign vec_text = shifted[MAX_PATTERN-1:0] & mask;
    // zero length selects no bit, so never hits
    assign hit      = |(vec_text & sel);

    always_comb
    begin
        vec_next       = vec_reg;
        offset_next    = offset_reg;
        found_next     = found_reg;
        out_match_next = 1'b0;
        out_start_next = '0;
        out_first_next = 1'b0;
        if (is_start)
        begin
            vec_next    = '0;
            offset_next = '0;
            found_next  = 1'b0;
        end
        else if (is_text)
        begin
            vec_next = vec_text;
            if (offset_reg != '1)
            begin
                offset_next = offset_reg + 1'b1;
            end
            if (hit)
            begin
                out_match_next = 1'b1;
                out_start_next = offset_reg - OW'(bit_pos);
                out_first_next = !found_reg;
                found_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg       <= '0;
            offset_reg    <= '0;
            found_reg     <= 1'b0;
            len_reg       <= bsas_pkg::LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vec_reg    <= vec_next;
            offset_reg <= offset_next;
            found_reg  <= found_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_match_reg <= out_match_next;
            out_start_reg <= out_start_next;
            out_first_reg <= out_first_next;
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (is_load && (32'(q_entry.pattern_index) == i))
            begin
                pat_reg[i] <= q_entry.data_byte;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_match       = out_match_reg;
    assign out_match_start = out_start_reg;
    assign out_first       = out_first_reg;

    `ASSERT_AT(a_b_found_set, clk, rst_n, (is_text && hit) |=> found_reg)
    `ASSERT_AT(a_b_start_clr, clk, rst_n, is_start |=> (!found_reg && (vec_reg == '0)))
    `ASSERT_AT(a_b_first_once, clk, rst_n, (q_pop && found_reg) |=> !out_first_reg)

endmodule

// ===== rtl/bitap_shift_and_search_unit.sv =====
// Channel   Dir  Fields (low bit up)
// s_axis    in   tuser: command[1:0]; tdata: data_byte[7:0], pattern_index[13:8]
// m_axis    out  tdata: match[0], match_start[32:1], first_match_res[33]
// cfg       in   cfg_wr_data: pattern_length[5:0], written when cfg_wr_en is high
//
// Throughput: one beat per cycle on both sides while m_axis_tready is high. An
// accepted beat is written into the queue, then popped into the back end's
// output register that drives m_axis. The rate is set by the vector update in
// the back end (parallel compare of the byte against all stored pattern bytes, shift, AND).
// Reset clears the queue, match vector, text offset, found flag and output
// valid, and sets pattern_length to 1; the pattern store is not cleared.
// Output stalls back up through a two-beat queue to s_axis_tready.
module bitap_shift_and_search_unit #(
    parameter int MAX_PATTERN = bsas_pkg::MAX_PATTERN_DEF,
    parameter int QUEUE_DEPTH = bsas_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // data_byte[7:0], pattern_index[13:8], zero pad
    input  logic [bsas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [bsas_pkg::CMD_W-1:0]       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // match[0], match_start[32:1], first_match_res[33], zero pad
    output logic [bsas_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // pattern_length register
    input  logic                             cfg_wr_en,
    input  logic [bsas_pkg::LEN_W-1:0]       cfg_wr_data
);

    localparam int BW = bsas_pkg::BYTE_W;
    localparam int IW = bsas_pkg::INDEX_W;
    localparam int OW = bsas_pkg::OFFSET_W;

    bsas_pkg::q_entry_t push_entry;
    bsas_pkg::q_entry_t head_entry;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               head_valid;

    logic               res_match;
    logic [OW-1:0]      res_start;
    logic               res_first;

    // front end: decode command, drop out-of-range loads
    bsas_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .command       (s_axis_tuser),
        .data_byte     (s_axis_tdata[BW-1:0]),
        .pattern_index (s_axis_tdata[BW+IW-1:BW]),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    // decoupling queue between classify and execute
    bsas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back end: pattern store, match vector, offset, output register
    bsas_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .q_valid         (head_valid),
        .q_entry         (head_entry),
        .q_pop           (q_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_match       (res_match),
        .out_match_start (res_start),
        .out_first       (res_first)
    );

    assign m_axis_tdata = {
        (bsas_pkg::OUT_TDATA_W - OW - 2)'(0),
        res_first,
        res_start,
        res_match
    };

endmodule
